>>> hw/rtl/rsmp_pkg.sv
`default_nettype none

package rsmp_pkg;

  // Audio samples are fixed 16-bit two's complement.
  localparam int SAMPLE_W = 16;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd2;

  // Where the samples of a result come from.
  typedef enum logic [1:0] {
    SRC_INTERP = 2'd0,
    SRC_PASS   = 2'd1,
    SRC_ERROR  = 2'd2
  } src_t;

  // Control handed to the merge/output stage with each result.
  typedef struct packed {
    src_t src;
    logic run_last;
    logic stream_end;
  } mrg_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsmp_in_if.sv
`default_nettype none

interface rsmp_in_if import rsmp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rsmp_out_if.sv
`default_nettype none

interface rsmp_out_if import rsmp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       run_last;
  logic                       stream_end;
  logic                       rate_error;

  modport source (output valid, output left_out, output right_out, output run_last,
                  output stream_end, output rate_error, input ready);
  modport sink   (input valid, input left_out, input right_out, input run_last,
                  input stream_end, input rate_error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rsmp_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Caller guarantees num < den * 2**QW and holds den stable while busy.
module rsmp_div #(
  parameter int NW = 24,
  parameter int DW = 16,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [NW+DW-1:0] num_ext;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  assign num_ext = {{DW{1'b0}}, num};
  assign trial   = {rem_r, quo_r[QW-1]};
  assign diff    = trial - {1'b0, den};
  assign ge      = (trial >= {1'b0, den});

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      cnt_nxt = CW'(QW);
      rem_nxt = num_ext[QW +: DW];
      quo_nxt = num[QW-1:0];
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> hw/rtl/rsmp_lane.sv
`default_nettype none

// One channel: (a*(den-rem) + b*rem) / den, rounded half away from zero,
// clamped to int16. Products, then |num| and 2|num|+den, then divide.
module rsmp_lane import rsmp_pkg::*; #(
  parameter int RB = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  input  logic [RB-1:0]              rem,
  input  logic [RB-1:0]              den,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] res
);

  // |num| <= 2**15 * den, so 2|num| + den fits PW bits unsigned
  localparam int PW = RB + SAMPLE_W + 1;

  logic                 st1_r, st2_r;
  logic [RB-1:0]        wa;
  logic signed [RB:0]   wa_s;
  logic signed [RB:0]   rem_s;
  logic signed [PW-1:0] pa_nxt, pb_nxt, pa_r, pb_r;
  logic signed [PW-1:0] sum;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        dvd, dvd_r;
  logic                 neg_r;
  logic                 div_busy;
  logic [SAMPLE_W-1:0]  q;
  logic [SAMPLE_W-1:0]  qn;

  assign wa     = den - rem;
  assign wa_s   = {1'b0, wa};
  assign rem_s  = {1'b0, rem};
  assign pa_nxt = PW'(a) * PW'(wa_s);
  assign pb_nxt = PW'(b) * PW'(rem_s);

  assign sum = pa_r + pb_r;
  assign neg = sum[PW-1];
  assign mag = neg ? PW'(-sum) : PW'(sum);
  assign dvd = {mag[PW-2:0], 1'b0} + PW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= 1'b0;
      st2_r <= 1'b0;
    end else begin
      st1_r <= start;
      st2_r <= st1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (st1_r) begin
      dvd_r <= dvd;
      neg_r <= neg;
    end
  end

  rsmp_div #(
    .NW (PW),
    .DW (RB + 1),
    .QW (SAMPLE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st2_r),
    .num   (dvd_r),
    .den   ({den, 1'b0}),
    .busy  (div_busy),
    .quo   (q),
    .rem   ()
  );

  // q <= 32768; only the positive side can overflow
  assign qn   = (~q) + 1'b1;
  assign res  = neg_r ? signed'(qn) : (q[SAMPLE_W-1] ? SAMPLE_MAX : signed'(q));
  assign busy = st1_r | st2_r | div_busy;

endmodule

`default_nettype wire

>>> hw/rtl/rsmp_merge.sv
`default_nettype none

// Joins the two lane results (or pass-through / error values) with the
// flags into the output register.
module rsmp_merge import rsmp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  mrg_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] lane_l,
  input  logic signed [SAMPLE_W-1:0] lane_r,
  input  logic signed [SAMPLE_W-1:0] pass_l,
  input  logic signed [SAMPLE_W-1:0] pass_r,
  output logic                       free,
  rsmp_out_if.source                 out_ch
);

  logic                       valid_r, valid_nxt;
  logic signed [SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [SAMPLE_W-1:0] right_r, right_nxt;
  logic                       run_last_r, run_last_nxt;
  logic                       end_r, end_nxt;
  logic                       err_r, err_nxt;

  always_comb begin
    valid_nxt    = valid_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    run_last_nxt = run_last_r;
    end_nxt      = end_r;
    err_nxt      = err_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt    = 1'b1;
      run_last_nxt = ctl.run_last;
      end_nxt      = ctl.stream_end;
      err_nxt      = (ctl.src == SRC_ERROR);
      unique case (ctl.src)
        SRC_INTERP: begin
          left_nxt  = lane_l;
          right_nxt = lane_r;
        end
        SRC_PASS: begin
          left_nxt  = pass_l;
          right_nxt = pass_r;
        end
        default: begin
          left_nxt  = '0;
          right_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    run_last_r <= run_last_nxt;
    end_r      <= end_nxt;
    err_r      <= err_nxt;
  end

  assign free              = !valid_r || out_ch.ready;
  assign out_ch.valid      = valid_r;
  assign out_ch.left_out   = left_r;
  assign out_ch.right_out  = right_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.stream_end = end_r;
  assign out_ch.rate_error = err_r;

endmodule

`default_nettype wire

>>> hw/rtl/stereo_linear_resampler.sv
// Stereo linear-interpolation sample-rate converter.
// in_ch carries one stereo frame per item (valid/ready); out_ch carries the
// output frames, each with run_last (last result of that input frame),
// stream_end (final frame of the buffer) and rate_error. cfg_we/cfg_index/
// cfg_data write in_rate, out_rate and frame_count; write them only while
// the block is idle.
// Frames are handled one at a time. Each result waits for the bit-serial
// phase divider; the two sample lanes work beside it and, at the default
// RATE_BITS, finish first. The first frame of a buffer also computes the
// buffer's output count with the same kind of divider. A rate error gives
// a single result. Reset (rst_n low, synchronous) restores 48000/48000/1
// and starts a fresh buffer. If the receiver stalls, the output register
// holds its result and the engine waits; the next frame is accepted once
// the last result of the current frame sits in the output register.
`default_nettype none

module stereo_linear_resampler import rsmp_pkg::*; #(
  parameter int RATE_BITS    = 20,
  parameter int FRAME_BITS   = 24,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [((RATE_BITS > FRAME_BITS) ? RATE_BITS : FRAME_BITS)-1:0] cfg_data,
  rsmp_in_if.sink                in_ch,
  rsmp_out_if.source             out_ch
);

  localparam int RB   = RATE_BITS;
  localparam int FB   = FRAME_BITS;
  localparam int MUW  = $clog2(MAX_UPSAMPLE + 1);
  localparam int TW   = FB + MUW;            // output count / number
  localparam int IW   = FB + 1;              // saturating output index
  localparam int MAXR = 2 * MAX_UPSAMPLE + 2; // results per frame, max
  localparam int CNTW = $clog2(MAXR + 1);
  localparam int SW   = ((IW > RB + 1) ? IW : RB + 1) + 1;
  localparam int LIMW = RB + MUW;
  localparam int PRW  = FB + RB;
  localparam int TNW  = FB + RB + 1;
  localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_TOT   = 8'b0000_1000,
    S_TWAIT = 8'b0001_0000,
    S_DEC   = 8'b0010_0000,
    S_WORK  = 8'b0100_0000,
    S_ERR   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [RB-1:0] in_rate_r, in_rate_nxt;
  logic [RB-1:0] out_rate_r, out_rate_nxt;
  logic [FB-1:0] frame_count_r, frame_count_nxt;

  // buffer position
  logic [FB-1:0] frames_seen_r, frames_seen_nxt;
  logic [TW-1:0] out_num_r, out_num_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [IW-1:0] out_idx_r, out_idx_nxt;
  logic [RB-1:0] phase_r, phase_nxt;

  // current and previous frame
  logic signed [SAMPLE_W-1:0] prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SAMPLE_W-1:0] cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;

  // per-frame bookkeeping
  logic            last_r, last_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [PRW-1:0]  prod_r, prod_nxt;
  logic            pend_r, pend_nxt;       // a result is waiting for its run_last
  src_t            pend_src_r, pend_src_nxt;
  logic            pend_end_r, pend_end_nxt;

  // datapath
  logic [FB-1:0]   n_eff;
  logic [LIMW-1:0] rate_lim;
  logic            bad_rate;
  logic            last_c;
  logic [IW-1:0]   i_ext;
  logic            idx_lt, idx_eq;
  logic            more;
  logic [RB-1:0]   rem_c;
  logic [RB:0]     step_num;
  logic [TNW-1:0]  tot_num;
  logic [SW-1:0]   idx_sum;
  logic [IW-1:0]   idx_sat;
  logic            end_c;

  logic          tot_start, tdiv_busy;
  logic [TW-1:0] tquo;
  logic          pdiv_start, pdiv_busy;
  logic [RB:0]   pquo;
  logic [RB-1:0] prem;

  logic                       lane_start, lane_l_busy, lane_r_busy;
  logic signed [SAMPLE_W-1:0] lane_l_res, lane_r_res;

  logic     mrg_load, mrg_free;
  mrg_ctl_t mctl;

  assign n_eff    = (frame_count_r == '0) ? FB'(1) : frame_count_r;
  assign rate_lim = LIMW'(in_rate_r) * LIMW'(MAX_UPSAMPLE);
  assign bad_rate = (in_rate_r == '0) || (out_rate_r == '0) ||
                    (LIMW'(out_rate_r) > rate_lim);
  assign last_c   = ((IW'(frames_seen_r) + IW'(1)) >= IW'(n_eff));

  assign i_ext  = IW'(frames_seen_r);
  assign idx_lt = (out_idx_r < i_ext);
  assign idx_eq = (out_idx_r == i_ext);
  // another result for this frame?
  assign more   = (out_num_r < total_r) && (cnt_r < CNTW'(MAXR)) &&
                  (idx_lt || (idx_eq && (phase_r == '0)) || last_r);

  // a stale remainder above out_rate weights the new frame fully
  assign rem_c    = (phase_r > out_rate_r) ? out_rate_r : phase_r;
  assign step_num = (RB + 1)'(phase_r) + (RB + 1)'(in_rate_r);
  assign tot_num  = TNW'(prod_r) + TNW'(in_rate_r >> 1);

  // index only matters against the frame number, so it saturates
  assign idx_sum = SW'(out_idx_r) + SW'(pquo);
  assign idx_sat = (idx_sum > SW'(IDX_MAX)) ? IDX_MAX : idx_sum[IW-1:0];
  assign end_c   = ((TW + 1)'(out_num_r) + (TW + 1)'(1)) == (TW + 1)'(total_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    in_rate_nxt     = in_rate_r;
    out_rate_nxt    = out_rate_r;
    frame_count_nxt = frame_count_r;
    frames_seen_nxt = frames_seen_r;
    out_num_nxt     = out_num_r;
    total_nxt       = total_r;
    out_idx_nxt     = out_idx_r;
    phase_nxt       = phase_r;
    prev_l_nxt      = prev_l_r;
    prev_r_nxt      = prev_r_r;
    cur_l_nxt       = cur_l_r;
    cur_r_nxt       = cur_r_r;
    last_nxt        = last_r;
    cnt_nxt         = cnt_r;
    prod_nxt        = prod_r;
    pend_nxt        = pend_r;
    pend_src_nxt    = pend_src_r;
    pend_end_nxt    = pend_end_r;
    tot_start       = 1'b0;
    pdiv_start      = 1'b0;
    lane_start      = 1'b0;
    mrg_load        = 1'b0;
    mctl.src        = pend_src_r;
    mctl.run_last   = !more;
    mctl.stream_end = pend_end_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_RATE:     in_rate_nxt     = cfg_data[RB-1:0];
        REG_OUT_RATE:    out_rate_nxt    = cfg_data[RB-1:0];
        REG_FRAME_COUNT: frame_count_nxt = cfg_data[FB-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_l_nxt = in_ch.left_sample;
          cur_r_nxt = in_ch.right_sample;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_rate) begin
          state_nxt = S_ERR;
        end else begin
          last_nxt  = last_c;
          cnt_nxt   = '0;
          state_nxt = (frames_seen_r == '0) ? S_MUL : S_DEC;
        end
      end
      S_MUL: begin
        prod_nxt  = PRW'(n_eff) * PRW'(out_rate_r);
        state_nxt = S_TOT;
      end
      S_TOT: begin
        tot_start = 1'b1;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (!tdiv_busy) begin
          total_nxt   = tquo;
          out_num_nxt = '0;
          out_idx_nxt = '0;
          phase_nxt   = '0;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        // release the held result once we know whether it closes the run
        if (!pend_r || mrg_free) begin
          mrg_load = pend_r;
          pend_nxt = 1'b0;
          if (more) begin
            pdiv_start   = 1'b1;
            lane_start   = idx_lt;
            pend_src_nxt = idx_lt ? SRC_INTERP : SRC_PASS;
            state_nxt    = S_WORK;
          end else begin
            frames_seen_nxt = last_r ? '0 : frames_seen_r + FB'(1);
            prev_l_nxt      = cur_l_r;
            prev_r_nxt      = cur_r_r;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_WORK: begin
        if (!pdiv_busy && !lane_l_busy && !lane_r_busy) begin
          pend_nxt     = 1'b1;
          pend_end_nxt = end_c;
          out_idx_nxt  = idx_sat;
          phase_nxt    = prem;
          out_num_nxt  = out_num_r + TW'(1);
          cnt_nxt      = cnt_r + CNTW'(1);
          state_nxt    = S_DEC;
        end
      end
      S_ERR: begin
        mctl.src        = SRC_ERROR;
        mctl.run_last   = 1'b1;
        mctl.stream_end = 1'b0;
        if (mrg_free) begin
          mrg_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      in_rate_r     <= RB'(48000);
      out_rate_r    <= RB'(48000);
      frame_count_r <= FB'(1);
      frames_seen_r <= '0;
      pend_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      in_rate_r     <= in_rate_nxt;
      out_rate_r    <= out_rate_nxt;
      frame_count_r <= frame_count_nxt;
      frames_seen_r <= frames_seen_nxt;
      pend_r        <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_num_r  <= out_num_nxt;
    total_r    <= total_nxt;
    out_idx_r  <= out_idx_nxt;
    phase_r    <= phase_nxt;
    prev_l_r   <= prev_l_nxt;
    prev_r_r   <= prev_r_nxt;
    cur_l_r    <= cur_l_nxt;
    cur_r_r    <= cur_r_nxt;
    last_r     <= last_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    pend_src_r <= pend_src_nxt;
    pend_end_r <= pend_end_nxt;
  end

  // output count of the buffer: (n*out_rate + in_rate/2) / in_rate
  rsmp_div #(
    .NW (TNW),
    .DW (RB),
    .QW (TW)
  ) u_tot_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tot_start),
    .num   (tot_num),
    .den   (in_rate_r),
    .busy  (tdiv_busy),
    .quo   (tquo),
    .rem   ()
  );

  // position step: (phase + in_rate) split over out_rate
  rsmp_div #(
    .NW (RB + 1),
    .DW (RB),
    .QW (RB + 1)
  ) u_phase_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pdiv_start),
    .num   (step_num),
    .den   (out_rate_r),
    .busy  (pdiv_busy),
    .quo   (pquo),
    .rem   (prem)
  );

  rsmp_lane #(.RB(RB)) u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .a     (prev_l_r),
    .b     (cur_l_r),
    .rem   (rem_c),
    .den   (out_rate_r),
    .busy  (lane_l_busy),
    .res   (lane_l_res)
  );

  rsmp_lane #(.RB(RB)) u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .a     (prev_r_r),
    .b     (cur_r_r),
    .rem   (rem_c),
    .den   (out_rate_r),
    .busy  (lane_r_busy),
    .res   (lane_r_res)
  );

  rsmp_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (mrg_load),
    .ctl    (mctl),
    .lane_l (lane_l_res),
    .lane_r (lane_r_res),
    .pass_l (cur_l_r),
    .pass_r (cur_r_r),
    .free   (mrg_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
